/* design/cht_pkg.sv */
// cht_pkg: sizes, codes and beat / control types for the chained hash table
// shared by the controller, the datapath, the top level and the checker
package cht_pkg;

  localparam int MAX_BUCKETS      = 16;
  localparam int CHAIN_DEPTH      = 8;
  localparam int KEY_W            = 32;
  localparam int CFG_W            = 5;
  localparam int BUCKETS_AT_RESET = 7;

  localparam int BKT_W     = $clog2(MAX_BUCKETS);
  localparam int SLOT_W    = $clog2(CHAIN_DEPTH);
  localparam int CNT_W     = $clog2(CHAIN_DEPTH + 1);
  localparam int ADDR_W    = BKT_W + SLOT_W;
  localparam int MEM_D     = MAX_BUCKETS * CHAIN_DEPTH;
  localparam int DIV_W     = BKT_W + 1;
  localparam int DIV_CNT_W = $clog2(KEY_W);

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_READ   = 2'd2,
    OP_NONE   = 2'd3
  } cht_op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_EMPTY     = 2'd3
  } cht_status_t;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [KEY_W-1:0] key;
    logic [3:0]       read_bucket;
    logic [2:0]       read_slot;
  } cht_in_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [3:0]       bucket_index;
    logic [3:0]       chain_length;
    logic [KEY_W-1:0] read_key;
  } cht_out_t;

  typedef struct packed {
    logic        load;
    logic        div_step;
    logic        idx_inc;
    logic        rd_en;
    logic        rd_nxt;
    logic        wr_en;
    logic        wr_ins;
    logic        cnt_inc;
    logic        cnt_dec;
    logic        st_we;
    cht_status_t st;
    logic        resp;
  } cht_cmd_t;

  typedef struct packed {
    cht_op_t op;
    logic    div_last;
    logic    full;
    logic    idx_end;
    logic    nxt_end;
    logic    hit;
    logic    rd_oob;
  } cht_sts_t;

endpackage

/* design/cht_datapath.sv */
// cht_datapath: bucket count register, serial modulo, chain slot memory,
// chain counts and result register; depends on cht_pkg
module cht_datapath import cht_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  cht_cmd_t         cmd,
  output cht_sts_t         sts,
  input  cht_in_t          in_data,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_data,
  output cht_out_t         out_data
);

  logic [CFG_W-1:0]     nbk_r;
  cht_op_t              op_r;
  logic [KEY_W-1:0]     key_r;
  logic [KEY_W-1:0]     key_sh_r;
  logic [BKT_W-1:0]     rb_r;
  logic [SLOT_W-1:0]    rs_r;
  logic [BKT_W-1:0]     rem_r;
  logic [BKT_W-1:0]     rem_nxt;
  logic [DIV_CNT_W-1:0] bitcnt_r;
  logic [CNT_W-1:0]     idx_r;
  cht_status_t          st_r;
  logic [KEY_W-1:0]     rd_data_r;
  cht_out_t             out_r;
  cht_out_t             out_nxt;

  logic [KEY_W-1:0] mem [MEM_D];
  logic [CNT_W-1:0] cnt_r [MAX_BUCKETS];

  logic [CFG_W-1:0]  div_eff;
  logic [DIV_W-1:0]  trial;
  logic [DIV_W-1:0]  diff;
  logic [BKT_W-1:0]  bkt;
  logic [CNT_W-1:0]  n;
  logic [CNT_W-1:0]  idx_p1;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr;
  logic [KEY_W-1:0]  wdata;

  // divisor clamped to the legal bucket range
  always_comb begin
    if (nbk_r == '0) begin
      div_eff = CFG_W'(1);
    end else if (nbk_r > CFG_W'(MAX_BUCKETS)) begin
      div_eff = CFG_W'(MAX_BUCKETS);
    end else begin
      div_eff = nbk_r;
    end
  end

  // one restoring step per cycle, msb first
  assign trial   = {rem_r, key_sh_r[KEY_W-1]};
  assign diff    = trial - DIV_W'(div_eff);
  assign rem_nxt = (trial >= DIV_W'(div_eff)) ? diff[BKT_W-1:0] : trial[BKT_W-1:0];

  assign bkt    = (op_r == OP_READ) ? rb_r : rem_r;
  assign n      = cnt_r[bkt];
  assign idx_p1 = idx_r + CNT_W'(1);

  assign waddr = cmd.wr_ins ? {bkt, n[SLOT_W-1:0]} : {bkt, idx_r[SLOT_W-1:0]};
  assign wdata = cmd.wr_ins ? key_r : rd_data_r;

  always_comb begin
    if (op_r == OP_READ) begin
      raddr = {rb_r, rs_r};
    end else if (cmd.rd_nxt) begin
      raddr = {bkt, idx_p1[SLOT_W-1:0]};
    end else begin
      raddr = {bkt, idx_r[SLOT_W-1:0]};
    end
  end

  assign sts.op       = op_r;
  assign sts.div_last = (bitcnt_r == DIV_CNT_W'(KEY_W - 1));
  assign sts.full     = (n >= CNT_W'(CHAIN_DEPTH));
  assign sts.idx_end  = (idx_r >= n);
  assign sts.nxt_end  = (idx_p1 >= n);
  assign sts.hit      = (rd_data_r == key_r);
  assign sts.rd_oob   = (CNT_W'(rs_r) >= n);

  always_comb begin
    out_nxt = '0;
    if (op_r != OP_NONE) begin
      out_nxt.status       = st_r;
      out_nxt.bucket_index = 4'(bkt);
      out_nxt.chain_length = 4'(n);
      if (op_r == OP_READ && st_r == ST_OK) begin
        out_nxt.read_key = rd_data_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nbk_r <= CFG_W'(BUCKETS_AT_RESET);
      for (int i = 0; i < MAX_BUCKETS; i++) begin
        cnt_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        nbk_r <= cfg_data;
      end
      if (cmd.cnt_inc) begin
        cnt_r[bkt] <= n + CNT_W'(1);
      end else if (cmd.cnt_dec) begin
        cnt_r[bkt] <= n - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= cht_op_t'(in_data.opcode);
      key_r    <= in_data.key;
      key_sh_r <= in_data.key;
      rb_r     <= BKT_W'(in_data.read_bucket);
      rs_r     <= SLOT_W'(in_data.read_slot);
      rem_r    <= '0;
      bitcnt_r <= '0;
      idx_r    <= '0;
      st_r     <= ST_OK;
    end else begin
      if (cmd.div_step) begin
        rem_r    <= rem_nxt;
        key_sh_r <= {key_sh_r[KEY_W-2:0], 1'b0};
        bitcnt_r <= bitcnt_r + DIV_CNT_W'(1);
      end
      if (cmd.idx_inc) begin
        idx_r <= idx_p1;
      end
      if (cmd.st_we) begin
        st_r <= cmd.st;
      end
    end
    if (cmd.resp) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[waddr] <= wdata;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[raddr];
    end
  end

  assign out_data = out_r;

endmodule

/* design/cht_ctrl.sv */
// cht_ctrl: sequencer for hash, insert, search, shift and read steps
// depends on cht_pkg
module cht_ctrl import cht_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  cht_sts_t sts,
  output cht_cmd_t cmd,
  output logic     busy,
  output logic     out_valid
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_HASH,
    S_INS,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_READ_RD,
    S_RESP
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   busy_r;
  logic   out_valid_r;
  logic   out_valid_nxt;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (sts.op == OP_INSERT || sts.op == OP_DELETE) begin
          state_nxt = S_HASH;
        end else if (sts.op == OP_READ) begin
          state_nxt = S_READ_RD;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_HASH: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = (sts.op == OP_INSERT) ? S_INS : S_SRCH_RD;
        end
      end
      S_INS: begin
        if (sts.full) begin
          cmd.st_we = 1'b1;
          cmd.st    = ST_FULL;
        end else begin
          cmd.wr_en   = 1'b1;
          cmd.wr_ins  = 1'b1;
          cmd.cnt_inc = 1'b1;
        end
        state_nxt = S_RESP;
      end
      S_SRCH_RD: begin
        if (sts.idx_end) begin
          cmd.st_we = 1'b1;
          cmd.st    = ST_NOT_FOUND;
          state_nxt = S_RESP;
        end else begin
          cmd.rd_en = 1'b1;
          state_nxt = S_SRCH_CMP;
        end
      end
      S_SRCH_CMP: begin
        if (sts.hit) begin
          state_nxt = S_SHIFT_RD;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_SRCH_RD;
        end
      end
      S_SHIFT_RD: begin
        if (sts.nxt_end) begin
          cmd.cnt_dec = 1'b1;
          state_nxt   = S_RESP;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_nxt = 1'b1;
          state_nxt  = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.idx_inc = 1'b1;
        state_nxt   = S_SHIFT_RD;
      end
      S_READ_RD: begin
        if (sts.rd_oob) begin
          cmd.st_we = 1'b1;
          cmd.st    = ST_EMPTY;
        end else begin
          cmd.rd_en = 1'b1;
        end
        state_nxt = S_RESP;
      end
      S_RESP: begin
        cmd.resp      = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      busy_r      <= (state_nxt != S_IDLE);
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;

endmodule

/* design/chained_hash_table_top.sv */
// chained_hash_table_top: hash table with separate chaining
// joins cht_ctrl and cht_datapath; depends on cht_pkg
//
// A command beat is taken when start is high and busy is low; busy then
// stays high until the result beat, which shows on out_data with out_valid
// high for exactly one cycle and cannot be held off. Each item walks through
// the sequencer: insert and delete first run the one-bit-per-cycle modulo of
// the key by the bucket count; insert then writes the key at the chain end or
// reports a full chain, delete searches the chain entry by entry and shifts
// each later entry down through the slot memory, a read fetches one slot or
// reports it empty, and an unused opcode goes straight to the result. The
// bucket count written on cfg_data is taken in any idle cycle.
module chained_hash_table_top import cht_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  cht_in_t          in_data,
  output logic             out_valid,
  output cht_out_t         out_data,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_data
);

  cht_cmd_t cmd;
  cht_sts_t sts;

  cht_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  cht_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .in_data  (in_data),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .out_data (out_data)
  );

endmodule

/* design/chained_hash_table_chk.sv */
// chained_hash_table_chk: port-level checks on the command / result beats
// bound to chained_hash_table_top; depends on cht_pkg
module chained_hash_table_chk import cht_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);

  // accepted beat holds off further commands
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted beat");

  // result beat frees the block
  a_idle_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("busy still high with result beat");

  // busy drops only together with a result
  a_result_on_release: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $past(busy) && !busy) |-> out_valid)
    else $error("busy released without a result beat");

  // no result right after an accept
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> !out_valid)
    else $error("result beat one cycle after accept");

endmodule

bind chained_hash_table_top chained_hash_table_chk u_chk (.*);

/* test/tb_top.sv */
// tb_top: self-checking testbench for chained_hash_table_top
// drives insert, delete, read and unused commands and checks every result beat
// depends on cht_pkg and the design files under design/
`timescale 1ns / 1ps

import cht_pkg::*;

class chain_table_mirror;
  bit [KEY_W-1:0] slots [MAX_BUCKETS][CHAIN_DEPTH];
  int unsigned    lens [MAX_BUCKETS];
  int unsigned    divisor = BUCKETS_AT_RESET;
  cht_out_t       replies [$];
  int unsigned    bad = 0;

  function void set_buckets(input logic [CFG_W-1:0] v);
    if (v == 0) begin
      divisor = 1;
    end else if (v > MAX_BUCKETS) begin
      divisor = MAX_BUCKETS;
    end else begin
      divisor = v;
    end
  endfunction

  function bit stored_key(output bit [KEY_W-1:0] k);
    int unsigned b;
    int unsigned tries;
    for (tries = 0; tries < 16; tries++) begin
      b = $urandom_range(MAX_BUCKETS - 1);
      if (lens[b] != 0) begin
        k = slots[b][$urandom_range(lens[b] - 1)];
        return 1'b1;
      end
    end
    k = '0;
    return 1'b0;
  endfunction

  function void note_command(input cht_in_t c);
    cht_out_t       r;
    int unsigned    b;
    int unsigned    n;
    int             hit;
    int unsigned    i;
    bit [KEY_W-1:0] k;
    r = '0;
    k = c.key;
    case (cht_op_t'(c.opcode))
      OP_INSERT: begin
        b = k % divisor;
        n = lens[b];
        r.bucket_index = 4'(b);
        if (n >= CHAIN_DEPTH) begin
          r.status = ST_FULL;
          r.chain_length = 4'(n);
        end else begin
          slots[b][n] = k;
          lens[b] = n + 1;
          r.status = ST_OK;
          r.chain_length = 4'(n + 1);
        end
      end
      OP_DELETE: begin
        b = k % divisor;
        n = lens[b];
        r.bucket_index = 4'(b);
        hit = -1;
        for (i = 0; i < n; i++) begin
          if (hit < 0 && slots[b][i] == k) hit = i;
        end
        if (hit < 0) begin
          r.status = ST_NOT_FOUND;
          r.chain_length = 4'(n);
        end else begin
          for (i = hit; i + 1 < n; i++) slots[b][i] = slots[b][i + 1];
          lens[b] = n - 1;
          r.status = ST_OK;
          r.chain_length = 4'(n - 1);
        end
      end
      OP_READ: begin
        b = c.read_bucket;
        n = lens[b];
        r.bucket_index = 4'(b);
        r.chain_length = 4'(n);
        if (c.read_slot >= n) begin
          r.status = ST_EMPTY;
        end else begin
          r.status = ST_OK;
          r.read_key = slots[b][c.read_slot];
        end
      end
      default: r = '0;
    endcase
    replies = {replies, r};
  endfunction

  function void check_reply(input cht_out_t got);
    cht_out_t want;
    if (replies.size() == 0) begin
      if (bad < 10) $display("unexpected result beat: %p", got);
      bad++;
      return;
    end
    want = replies.pop_front();
    if (got.status !== want.status || got.bucket_index !== want.bucket_index ||
        got.chain_length !== want.chain_length || got.read_key !== want.read_key) begin
      if (bad < 10) begin
        $display("mismatch at %0t: status %0d/%0d bucket %0d/%0d length %0d/%0d key %h/%h",
                 $realtime, got.status, want.status, got.bucket_index, want.bucket_index,
                 got.chain_length, want.chain_length, got.read_key, want.read_key);
      end
      bad++;
    end
  endfunction
endclass

module tb_top;

  localparam int STALL_LIMIT = 4000;
  localparam int PHASE_ITEMS = 115;

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  cht_in_t          in_data;
  logic             out_valid;
  cht_out_t         out_data;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_data;

  chain_table_mirror mirror;
  int unsigned       idle_pct = 0;
  int unsigned       stall_cycles = 0;

  chained_hash_table_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (start && !busy) mirror.note_command(in_data);
      if (out_valid) mirror.check_reply(out_data);
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic cht_in_t cmd(input cht_op_t op, input logic [KEY_W-1:0] k,
                                  input logic [3:0] rb, input logic [2:0] rs);
    cht_in_t c;
    c.opcode = op;
    c.key = k;
    c.read_bucket = rb;
    c.read_slot = rs;
    return c;
  endfunction

  function automatic cht_in_t rand_command();
    cht_in_t        c;
    int unsigned    sel;
    bit [KEY_W-1:0] k;
    c.opcode = OP_NONE;
    c.key = $urandom;
    c.read_bucket = 4'($urandom);
    c.read_slot = 3'($urandom);
    sel = $urandom_range(99);
    if (sel < 42) begin
      c.opcode = OP_INSERT;
      if ($urandom_range(1)) c.key = $urandom_range(63);
    end else if (sel < 72) begin
      c.opcode = OP_DELETE;
      if ($urandom_range(9) < 7 && mirror.stored_key(k)) begin
        c.key = k;
      end else if ($urandom_range(1)) begin
        c.key = $urandom_range(63);
      end
    end else if (sel < 95) begin
      c.opcode = OP_READ;
      if ($urandom_range(9) < 6) c.read_bucket = 4'($urandom_range(mirror.divisor - 1));
    end
    return c;
  endfunction

  // holds start high except in random idle cycles until the beat is taken
  task automatic send_command(input cht_in_t c);
    bit taken;
    in_data <= c;
    do begin
      start <= ($urandom_range(99) >= idle_pct);
      @(posedge clk);
      taken = start && !busy;
    end while (!taken);
  endtask

  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (mirror.replies.size() != 0 || busy) @(posedge clk);
  endtask

  task automatic set_buckets(input logic [CFG_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    mirror.set_buckets(v);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [CFG_W-1:0] settings [6];
    int unsigned      p;
    int unsigned      i;
    mirror = new;
    settings = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd5, 5'd12};
    rst_n <= 1'b0;
    start <= 1'b0;
    in_data <= '0;
    cfg_we <= 1'b0;
    cfg_data <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset bucket count: empty reads, duplicates, delete with shift, full chain
    send_command(cmd(OP_READ, 32'd0, 4'd0, 3'd0));
    send_command(cmd(OP_INSERT, 32'd0, 4'd15, 3'd7));
    send_command(cmd(OP_INSERT, 32'hFFFF_FFFF, 4'd0, 3'd0));
    send_command(cmd(OP_INSERT, 32'd7, 4'd5, 3'd2));
    send_command(cmd(OP_INSERT, 32'd14, 4'd10, 3'd5));
    send_command(cmd(OP_INSERT, 32'd0, 4'd3, 3'd1));
    send_command(cmd(OP_READ, 32'hFFFF_FFFF, 4'd0, 3'd1));
    send_command(cmd(OP_READ, 32'd0, 4'd0, 3'd7));
    send_command(cmd(OP_DELETE, 32'd7, 4'd0, 3'd0));
    send_command(cmd(OP_READ, 32'd0, 4'd0, 3'd1));
    send_command(cmd(OP_DELETE, 32'd0, 4'd9, 3'd4));
    send_command(cmd(OP_DELETE, 32'd21, 4'd0, 3'd0));
    send_command(cmd(OP_NONE, 32'hA5A5_5A5A, 4'd15, 3'd7));
    send_command(cmd(OP_READ, 32'd0, 4'd15, 3'd0));
    for (i = 0; i < 8; i++) begin
      send_command(cmd(OP_INSERT, 32'd3 + 32'd7 * i, 4'(i), 3'(i)));
    end
    send_command(cmd(OP_READ, 32'd0, 4'd3, 3'd7));
    send_command(cmd(OP_DELETE, 32'hFFFF_FFFF, 4'd0, 3'd0));
    send_command(cmd(OP_READ, 32'd0, 4'd3, 3'd7));
    settle();

    for (p = 0; p < 6; p++) begin
      set_buckets(settings[p]);
      idle_pct = (p < 2) ? 23 : (p < 4) ? 53 : 0;
      for (i = 0; i < PHASE_ITEMS; i++) send_command(rand_command());
      settle();
    end

    repeat (64) @(posedge clk);
    if (mirror.bad == 0 && mirror.replies.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
